// ===== rtl/core/fddi_pcm_pkg.sv =====
package fddi_pcm_pkg;

	// connection phase codes
	localparam logic [2:0] PH_OFF  = 3'd0;
	localparam logic [2:0] PH_SIG  = 3'd1;
	localparam logic [2:0] PH_LCT  = 3'd2;
	localparam logic [2:0] PH_JOIN = 3'd3;
	localparam logic [2:0] PH_ACT  = 3'd4;

	// line state commands
	localparam logic [2:0] LC_STOP  = 3'd0;
	localparam logic [2:0] LC_START = 3'd1;
	localparam logic [2:0] LC_IDLE  = 3'd2;
	localparam logic [2:0] LC_LOOP  = 3'd3;
	localparam logic [2:0] LC_JOIN  = 3'd4;

	// event codes
	localparam logic [2:0] EV_START = 3'd0;
	localparam logic [2:0] EV_STOP  = 3'd1;
	localparam logic [2:0] EV_BREAK = 3'd2;
	localparam logic [2:0] EV_CODE  = 3'd3;
	localparam logic [2:0] EV_EN    = 3'd4;
	localparam logic [2:0] EV_TRACE = 3'd5;

	// register word index
	localparam logic REG_OWN_TYPE = 1'b0;
	localparam logic REG_LOOPBACK = 1'b1;

	localparam logic [1:0] OWN_TYPE_RST = 2'd2;
	localparam logic [1:0] LOOPBACK_RST = 2'd0;

	// bit count at the end of each signalling group
	localparam logic [3:0] BC_GRP1 = 4'd3;
	localparam logic [3:0] BC_GRP2 = 4'd7;
	localparam logic [3:0] BC_GRP3 = 4'd8;
	localparam logic [3:0] BC_GRP4 = 4'd10;

	localparam int NBITS = 10;

	// result item, first field in the high bits
	typedef struct packed {
		logic [1:0] loop_select;
		logic [1:0] peer_kind;
		logic       restarted;
		logic       link_up;
		logic [1:0] test_length;
		logic [2:0] tx_length;
		logic [3:0] tx_vector;
		logic [2:0] line_command;
		logic [2:0] phase;
	} pcm_result_t;

	localparam int RES_W = $bits(pcm_result_t);

endpackage

// ===== rtl/core/fddi_pcm_signalling_fsm_unit.sv =====
// an accepted input transaction passes the input register and then the result register,
// from which its result is offered on the result side
// throughput: one event per cycle; the input register and the result register
// move together, so s_tready stays high while the result side keeps up
// reset: arst_n clears the connection state to off / stop, the own port type to S (2)
// and loopback_mode to none; no clearing pass is needed
module fddi_pcm_signalling_fsm_unit import fddi_pcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // rx_bits[3:0], break_reason[6:4], link_errors[14:7]
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // phase[2:0], line_command[5:3], tx_vector[9:6],
	                              // tx_length[12:10], test_length[14:13], link_up[15],
	                              // restarted[16], peer_kind[18:17], loop_select[20:19]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [1:0] own_type_q;
	logic [1:0] loopback_q;

	// input stage
	logic       valid_s1;
	logic [2:0] ev_s1;
	logic [3:0] rx_s1;
	logic [2:0] reason_s1;
	logic [7:0] errs_s1;

	// result stage
	logic        valid_s2;
	pcm_result_t res_s2;

	// connection state
	logic [2:0]       phase_q;
	logic [3:0]       bc_q;
	logic [NBITS-1:0] sent_q;
	logic [NBITS-1:0] recv_q;
	logic [1:0]       peer_q;
	logic [3:0]       txg_q;
	logic [2:0]       txc_q;
	logic [2:0]       cmd_q;
	logic [1:0]       tls_q;
	logic             joined_q;
	logic [1:0]       loop_q;

	// next state
	logic [2:0]       nxt_phase;
	logic [3:0]       nxt_bc;
	logic [NBITS-1:0] nxt_sent;
	logic [NBITS-1:0] nxt_recv;
	logic [1:0]       nxt_peer;
	logic [3:0]       nxt_txg;
	logic [2:0]       nxt_txc;
	logic [2:0]       nxt_cmd;
	logic [1:0]       nxt_tls;
	logic             nxt_joined;
	logic [1:0]       nxt_loop;
	logic             do_restart;
	logic [NBITS-1:0] recv_upd;
	logic [3:0]       bc_new;
	pcm_result_t      res;

	logic adv;
	logic cfg_wr;

	// apb port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[2])
			REG_OWN_TYPE: prdata = {30'd0, own_type_q};
			REG_LOOPBACK: prdata = {30'd0, loopback_q};
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_type_q <= OWN_TYPE_RST;
			loopback_q <= LOOPBACK_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_OWN_TYPE: own_type_q <= pwdata[1:0];
				REG_LOOPBACK: loopback_q <= pwdata[1:0];
				default:      ;
			endcase
		end
	end

	// handshake: stage 1 moves on whenever the result register is free or drains
	assign adv      = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(24 - RES_W){1'b0}}, res_s2};

	// received group merged into the stored bits
	always_comb begin
		logic [3:0] off;
		logic [3:0] pos;
		recv_upd = recv_q;
		for (int p = 0; p < NBITS; p++) begin
			pos = 4'(p);
			off = pos - bc_q;
			if (pos >= bc_q && off < {1'b0, txc_q} && off < 4'd4)
				recv_upd[p] = rx_s1[off[1:0]];
		end
	end

	assign bc_new = bc_q + {1'b0, txc_q};

	// event handling
	always_comb begin
		nxt_phase  = phase_q;
		nxt_bc     = bc_q;
		nxt_sent   = sent_q;
		nxt_recv   = recv_q;
		nxt_peer   = peer_q;
		nxt_txg    = txg_q;
		nxt_txc    = txc_q;
		nxt_cmd    = cmd_q;
		nxt_tls    = tls_q;
		nxt_joined = joined_q;
		nxt_loop   = loop_q;
		do_restart = 1'b0;

		case (ev_s1)
			EV_START: begin
				nxt_loop    = loopback_q;
				nxt_sent[0] = 1'b0;
				nxt_sent[1] = own_type_q[1];
				nxt_sent[2] = own_type_q[0];
				nxt_sent[4] = 1'b0;
				nxt_sent[5] = 1'b0;
				nxt_sent[6] = 1'b0;
				nxt_sent[8] = 1'b0;
				nxt_sent[9] = 1'b1;
				do_restart  = 1'b1;
			end
			EV_STOP: begin
				nxt_joined = 1'b0;
				nxt_cmd    = LC_STOP;
				nxt_phase  = PH_OFF;
			end
			EV_BREAK: begin
				if (reason_s1 != 3'd0 && phase_q != PH_OFF)
					do_restart = 1'b1;
			end
			EV_CODE: begin
				if (phase_q == PH_SIG) begin
					nxt_recv = recv_upd;
					nxt_bc   = bc_new;
					case (bc_new)
						BC_GRP1: begin
							if (recv_upd[0]) begin
								do_restart = 1'b1;
							end else begin
								nxt_peer    = {recv_upd[1], recv_upd[2]};
								nxt_sent[3] = 1'b1;
								nxt_txg     = {sent_q[6], sent_q[5], sent_q[4], 1'b1};
								nxt_txc     = 3'd4;
							end
						end
						BC_GRP2: begin
							// longer of the two requested test lengths
							if ({recv_upd[4], recv_upd[5]} > {sent_q[4], sent_q[5]})
								nxt_tls = {recv_upd[4], recv_upd[5]};
							else
								nxt_tls = {sent_q[4], sent_q[5]};
							nxt_cmd   = recv_upd[6] ? LC_LOOP : LC_IDLE;
							nxt_phase = PH_LCT;
						end
						BC_GRP3: begin
							if (sent_q[7] || recv_upd[7]) begin
								// failed short test asks for medium next time
								if (!sent_q[4] && !sent_q[5])
									nxt_sent[5] = 1'b1;
								do_restart = 1'b1;
							end else begin
								nxt_txg = {2'b00, sent_q[9], sent_q[8]};
								nxt_txc = 3'd2;
							end
						end
						BC_GRP4: begin
							nxt_cmd   = LC_JOIN;
							nxt_phase = PH_JOIN;
						end
						default: ;
					endcase
				end else if (phase_q == PH_LCT) begin
					nxt_sent[7] = (errs_s1 != 8'd0);
					nxt_cmd     = LC_START;
					nxt_txg     = {3'b000, errs_s1 != 8'd0};
					nxt_txc     = 3'd1;
					nxt_phase   = PH_SIG;
				end
			end
			EV_EN: begin
				if (phase_q == PH_JOIN) begin
					nxt_phase  = PH_ACT;
					nxt_joined = 1'b1;
				end
			end
			EV_TRACE: begin
				if (phase_q == PH_ACT) begin
					nxt_joined = 1'b0;
					nxt_cmd    = LC_STOP;
					nxt_phase  = PH_OFF;
				end
			end
			default: ;
		endcase

		// restart of signalling: first group is escape flag and port type
		if (do_restart) begin
			nxt_joined = 1'b0;
			nxt_bc     = 4'd0;
			nxt_txg    = {1'b0, nxt_sent[2:0]};
			nxt_txc    = 3'd3;
			nxt_cmd    = LC_START;
			nxt_phase  = PH_SIG;
		end
	end

	// result from the updated state
	always_comb begin
		res.phase        = nxt_phase;
		res.line_command = nxt_cmd;
		res.tx_vector    = nxt_txg;
		res.tx_length    = nxt_txc;
		res.test_length  = nxt_tls;
		res.link_up      = nxt_joined;
		res.restarted    = do_restart;
		res.peer_kind    = nxt_peer;
		res.loop_select  = nxt_loop;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ev_s1     <= s_tuser;
			rx_s1     <= s_tdata[3:0];
			reason_s1 <= s_tdata[6:4];
			errs_s1   <= s_tdata[14:7];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	// connection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OFF;
			bc_q     <= 4'd0;
			sent_q   <= '0;
			recv_q   <= '0;
			peer_q   <= 2'd0;
			txg_q    <= 4'd0;
			txc_q    <= 3'd1;
			cmd_q    <= LC_STOP;
			tls_q    <= 2'd0;
			joined_q <= 1'b0;
			loop_q   <= 2'd0;
		end else if (adv) begin
			phase_q  <= nxt_phase;
			bc_q     <= nxt_bc;
			sent_q   <= nxt_sent;
			recv_q   <= nxt_recv;
			peer_q   <= nxt_peer;
			txg_q    <= nxt_txg;
			txc_q    <= nxt_txc;
			cmd_q    <= nxt_cmd;
			tls_q    <= nxt_tls;
			joined_q <= nxt_joined;
			loop_q   <= nxt_loop;
		end
	end

endmodule

// ===== rtl/core/fddi_pcm_chk.sv =====
module fddi_pcm_chk import fddi_pcm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	pcm_result_t res;

	assign res = pcm_result_t'(m_tdata[RES_W-1:0]);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// link is up exactly while active
	a_link_up: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.link_up == (res.phase == PH_ACT)))
		else $error("link_up disagrees with phase");

	// a restart leaves signalling with the first three-bit group
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.restarted |->
			res.phase == PH_SIG && res.line_command == LC_START && res.tx_length == 3'd3)
		else $error("restart result malformed");

	// link test runs with idle or loop command only
	a_lct_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.phase == PH_LCT |->
			res.line_command == LC_IDLE || res.line_command == LC_LOOP)
		else $error("bad line command during link test");

endmodule

bind fddi_pcm_signalling_fsm_unit fddi_pcm_chk u_fddi_pcm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
